FILE: sv/slfr_pkg.sv
// Package for the length-prefixed frame receiver: status codes, register map,
// frame constants, result struct and the byte-wide reflected CRC-16 update.
// No dependencies.
package slfr_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        STATUS_BUSY      = 3'd0,
        STATUS_PAYLOAD   = 3'd1,
        STATUS_GOOD      = 3'd2,
        STATUS_CRC_BAD   = 3'd3,
        STATUS_SYNC_DROP = 3'd4,
        STATUS_TIMEOUT   = 3'd5
    } status_t;

    // Register map: word index taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_CRC_POLY = 2'd0,
        REG_CRC_INIT = 2'd1,
        REG_TIMEOUT  = 2'd2
    } reg_idx_t;

    localparam int          PADDR_W        = 4;
    localparam logic [15:0] CRC_POLY_RESET = 16'hA001;
    localparam logic [15:0] CRC_INIT_RESET = 16'h0000;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd100;

    localparam logic [7:0]  SYNC_BYTE      = 8'h80;
    localparam logic [8:0]  HDR_SIZE       = 9'd14;
    localparam logic [8:0]  POS_DST_FIRST  = 9'd1;
    localparam logic [8:0]  POS_DST_LAST   = 9'd3;
    localparam logic [8:0]  POS_SYNC2      = 9'd5;
    localparam logic [8:0]  POS_SRC_FIRST  = 9'd6;
    localparam logic [8:0]  POS_SRC_LAST   = 9'd8;
    localparam logic [8:0]  POS_LEN        = 9'd10;
    localparam logic [8:0]  POS_CMD        = 9'd13;
    localparam logic [15:0] IDLE_MAX       = 16'hFFFF;

    typedef struct packed {
        status_t     status;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [23:0] dest_address;
        logic [23:0] src_address;
        logic [7:0]  payload_length;
        logic [7:0]  command_code;
    } result_t;

    typedef struct packed {
        logic [15:0] crc_poly;
        logic [15:0] crc_init;
        logic [15:0] timeout;
    } cfg_t;

    // One byte through a reflected CRC-16, LSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  data,
                                               input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: sv/slfr_frame_core.sv
// Frame tracking state and per-item decode for the frame receiver.
// Depends on slfr_pkg.
module slfr_frame_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  logic                 operation,
    input  logic [7:0]           rx_byte,
    input  slfr_pkg::cfg_t       cfg,
    output slfr_pkg::result_t    result
);

    logic [8:0]  pos_reg,  pos_next;
    logic [7:0]  len_reg,  len_next;
    logic [15:0] crc_reg,  crc_next;
    logic [7:0]  crcl_reg, crcl_next;
    logic [23:0] dst_reg,  dst_next;
    logic [23:0] src_reg,  src_next;
    logic [7:0]  cmd_reg,  cmd_next;
    logic [15:0] idle_reg, idle_next;

    logic [15:0] crc_work;
    logic [8:0]  crc_end;
    logic [8:0]  pay_off;

    always_comb begin
        pos_next  = pos_reg;
        len_next  = len_reg;
        crc_next  = crc_reg;
        crcl_next = crcl_reg;
        dst_next  = dst_reg;
        src_next  = src_reg;
        cmd_next  = cmd_reg;
        idle_next = idle_reg;
        result    = '0;
        result.status = slfr_pkg::STATUS_BUSY;
        crc_work  = (pos_reg == '0) ? cfg.crc_init : crc_reg;
        crc_end   = slfr_pkg::HDR_SIZE + {1'b0, len_reg};
        pay_off   = pos_reg - slfr_pkg::HDR_SIZE;

        if (operation) begin
            // idle tick
            if (idle_reg != slfr_pkg::IDLE_MAX) begin
                idle_next = idle_reg + 16'd1;
            end
            if (pos_reg != '0 && idle_next > cfg.timeout) begin
                pos_next      = '0;
                result.status = slfr_pkg::STATUS_TIMEOUT;
            end
        end else begin
            idle_next = '0;
            if ((pos_reg == '0 || pos_reg == slfr_pkg::POS_SYNC2) &&
                rx_byte != slfr_pkg::SYNC_BYTE) begin
                pos_next      = '0;
                result.status = slfr_pkg::STATUS_SYNC_DROP;
            end else begin
                if (pos_reg >= slfr_pkg::POS_DST_FIRST && pos_reg <= slfr_pkg::POS_DST_LAST) begin
                    dst_next = {dst_reg[15:0], rx_byte};
                end else if (pos_reg >= slfr_pkg::POS_SRC_FIRST &&
                             pos_reg <= slfr_pkg::POS_SRC_LAST) begin
                    src_next = {src_reg[15:0], rx_byte};
                end else if (pos_reg == slfr_pkg::POS_LEN) begin
                    len_next = rx_byte;
                end else if (pos_reg == slfr_pkg::POS_CMD) begin
                    cmd_next = rx_byte;
                end

                if (pos_reg < slfr_pkg::HDR_SIZE || pos_reg < crc_end) begin
                    crc_next = slfr_pkg::crc16_byte(crc_work, rx_byte, cfg.crc_poly);
                end else begin
                    crc_next = crc_work;
                end

                if (pos_reg >= slfr_pkg::HDR_SIZE && pos_reg < crc_end) begin
                    result.status        = slfr_pkg::STATUS_PAYLOAD;
                    result.payload_byte  = rx_byte;
                    result.payload_index = pay_off[7:0];
                    pos_next             = pos_reg + 9'd1;
                end else if (pos_reg >= slfr_pkg::HDR_SIZE && pos_reg == crc_end) begin
                    crcl_next = rx_byte;
                    pos_next  = pos_reg + 9'd1;
                end else if (pos_reg >= slfr_pkg::HDR_SIZE && pos_reg == crc_end + 9'd1) begin
                    // trailing CRC, low byte first
                    result.status = ({rx_byte, crcl_reg} == crc_reg) ?
                                    slfr_pkg::STATUS_GOOD : slfr_pkg::STATUS_CRC_BAD;
                    result.dest_address   = dst_reg;
                    result.src_address    = src_reg;
                    result.payload_length = len_reg;
                    result.command_code   = cmd_reg;
                    pos_next              = '0;
                end else begin
                    pos_next = pos_reg + 9'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            len_reg  <= '0;
            crc_reg  <= '0;
            crcl_reg <= '0;
            dst_reg  <= '0;
            src_reg  <= '0;
            cmd_reg  <= '0;
            idle_reg <= '0;
        end else if (step_en) begin
            pos_reg  <= pos_next;
            len_reg  <= len_next;
            crc_reg  <= crc_next;
            crcl_reg <= crcl_next;
            dst_reg  <= dst_next;
            src_reg  <= src_next;
            cmd_reg  <= cmd_next;
            idle_reg <= idle_next;
        end
    end

endmodule

FILE: sv/sync_length_frame_receiver_crc_top.sv
// Length-prefixed frame receiver with reflected CRC-16 check: top level.
// Path: the input handshake loads the input reg, and the core result then moves into the
// result reg once it has room (empty, or being emptied).
// Throughput: one item per cycle; the CRC byte update is unrolled in the core.
// A stalled result holds the result reg; the input reg takes one more item, then
// s_ready drops until m_ready returns. Reset: synchronous active-low aresetn clears
// pipeline valids, frame state and loads the register defaults (poly 0xA001,
// initial 0, timeout 100). Depends on slfr_pkg and slfr_frame_core.
module sync_length_frame_receiver_crc_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [7:0]  s_rx_byte,
    // result items
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [7:0]  m_payload_byte,
    output logic [7:0]  m_payload_index,
    output logic [23:0] m_dest_address,
    output logic [23:0] m_src_address,
    output logic [7:0]  m_payload_length,
    output logic [7:0]  m_command_code,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [slfr_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    slfr_pkg::cfg_t cfg_reg;
    logic           cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.crc_poly <= slfr_pkg::CRC_POLY_RESET;
            cfg_reg.crc_init <= slfr_pkg::CRC_INIT_RESET;
            cfg_reg.timeout  <= slfr_pkg::TIMEOUT_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                slfr_pkg::REG_CRC_POLY: cfg_reg.crc_poly <= pwdata[15:0];
                slfr_pkg::REG_CRC_INIT: cfg_reg.crc_init <= pwdata[15:0];
                slfr_pkg::REG_TIMEOUT:  cfg_reg.timeout  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            slfr_pkg::REG_CRC_POLY: prdata = {16'h0000, cfg_reg.crc_poly};
            slfr_pkg::REG_CRC_INIT: prdata = {16'h0000, cfg_reg.crc_init};
            slfr_pkg::REG_TIMEOUT:  prdata = {16'h0000, cfg_reg.timeout};
            default:                prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Input register: holds one item; released when the result
    // register has room (empty, or being emptied this cycle).
    // ---------------------------------------------------------------
    logic       in_valid_reg;
    logic       op_reg;
    logic [7:0] byte_reg;
    logic       advance;
    logic       s_take;

    assign advance = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            op_reg   <= s_operation;
            byte_reg <= s_rx_byte;
        end
    end

    // ---------------------------------------------------------------
    // Frame core: state moves on when the held item goes forward
    // ---------------------------------------------------------------
    slfr_pkg::result_t core_res;

    slfr_frame_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .operation (op_reg),
        .rx_byte   (byte_reg),
        .cfg       (cfg_reg),
        .result    (core_res)
    );

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic              out_valid_reg;
    slfr_pkg::result_t res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= core_res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_status         = res_reg.status;
    assign m_payload_byte   = res_reg.payload_byte;
    assign m_payload_index  = res_reg.payload_index;
    assign m_dest_address   = res_reg.dest_address;
    assign m_src_address    = res_reg.src_address;
    assign m_payload_length = res_reg.payload_length;
    assign m_command_code   = res_reg.command_code;

endmodule

FILE: sv/slfr_checker.sv
// Port-level checks for the frame receiver top, attached by bind.
// Depends on slfr_pkg.
module slfr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [7:0]  m_payload_byte,
    input logic [7:0]  m_payload_index,
    input logic [23:0] m_dest_address,
    input logic [23:0] m_src_address,
    input logic [7:0]  m_payload_length,
    input logic [7:0]  m_command_code
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_payload_byte))
        else $error("result changed while stalled");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= slfr_pkg::STATUS_TIMEOUT)
        else $error("status code out of range");

    a_payload_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != slfr_pkg::STATUS_PAYLOAD |->
            m_payload_byte == '0 && m_payload_index == '0)
        else $error("payload fields set on a non-payload item");

    a_frame_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != slfr_pkg::STATUS_GOOD && m_status != slfr_pkg::STATUS_CRC_BAD |->
            m_dest_address == '0 && m_src_address == '0 &&
            m_payload_length == '0 && m_command_code == '0)
        else $error("frame fields set on an unfinished item");

endmodule

bind sync_length_frame_receiver_crc_top slfr_checker u_slfr_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_status         (m_status),
    .m_payload_byte   (m_payload_byte),
    .m_payload_index  (m_payload_index),
    .m_dest_address   (m_dest_address),
    .m_src_address    (m_src_address),
    .m_payload_length (m_payload_length),
    .m_command_code   (m_command_code)
);

FILE: tb/tb.sv
// Self-checking bench for sync_length_frame_receiver_crc_top: directed frames and
// random frame traffic, checked by a built-in frame predictor.
// Needs slfr_pkg and the receiver RTL; nothing else.
`timescale 1ns / 100ps

module tb;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 6;
    localparam int STALL_LIMIT   = 4000;  // cycles with no item moving on either side
    localparam int HOLD_CYCLES   = 600;   // long receiver hold-off
    localparam int TAIL_CYCLES   = 8;     // well past the pipeline depth
    localparam int RAND_ITEMS    = 1525;
    localparam int PHASE_ITEMS   = 194;
    localparam int LONG_AFTER    = 700;   // random items before the one 255-byte payload
    localparam int TX_CALM_FIRST = 1000;  // random items sent with no sender idling
    localparam int TX_CALM_LAST  = 1250;
    localparam int RX_CALM_FIRST = 1500;  // cycles with ready held high
    localparam int RX_CALM_LAST  = 2100;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // where the driven byte comes from: the item itself, or the running CRC
    // (low or high byte) xor the item's data, so a non-zero data corrupts it
    typedef enum logic [1:0] {
        SRC_DATA,
        SRC_CRC_LO,
        SRC_CRC_HI
    } byte_src_t;

    typedef struct packed {
        logic              op;
        logic [7:0]        data;
        byte_src_t         src;
        logic              literal;     // expected result typed in below
        slfr_pkg::status_t lit_status;
    } stim_t;

    // Directed items, default registers after reset. Literal rows expect an
    // all-zero result apart from the status; the rest go through the predictor.
    localparam stim_t DIRECTED [25] = '{
        '{OP_TICK, 8'h00, SRC_DATA,   1'b1, slfr_pkg::STATUS_BUSY},      // tick, no frame
        '{OP_BYTE, 8'hFF, SRC_DATA,   1'b1, slfr_pkg::STATUS_SYNC_DROP}, // bad first sync
        '{OP_BYTE, 8'h80, SRC_DATA,   1'b0, slfr_pkg::STATUS_BUSY},
        '{OP_BYTE, 8'h12, SRC_DATA,   1'b0, slfr_pkg::STATUS_BUSY},
        '{OP_BYTE, 8'h34, SRC_DATA,   1'b0, slfr_pkg::STATUS_BUSY},
        '{OP_BYTE, 8'h56, SRC_DATA,   1'b0, slfr_pkg::STATUS_BUSY},
        '{OP_BYTE, 8'h00, SRC_DATA,   1'b0, slfr_pkg::STATUS_BUSY},
        '{OP_BYTE, 8'h7F, SRC_DATA,   1'b1, slfr_pkg::STATUS_SYNC_DROP}, // bad second sync
        // full frame, extreme header fields, one payload byte, correct CRC
        '{OP_BYTE, 8'h80, SRC_DATA,   1'b0, slfr_pkg::STATUS_BUSY},
        '{OP_BYTE, 8'hFF, SRC_DATA,   1'b0, slfr_pkg::STATUS_BUSY},
        '{OP_BYTE, 8'hFF, SRC_DATA,   1'b0, slfr_pkg::STATUS_BUSY},
        '{OP_BYTE, 8'hFF, SRC_DATA,   1'b0, slfr_pkg::STATUS_BUSY},
        '{OP_BYTE, 8'h00, SRC_DATA,   1'b0, slfr_pkg::STATUS_BUSY},
        '{OP_BYTE, 8'h80, SRC_DATA,   1'b0, slfr_pkg::STATUS_BUSY},
        '{OP_BYTE, 8'h00, SRC_DATA,   1'b0, slfr_pkg::STATUS_BUSY},
        '{OP_BYTE, 8'h00, SRC_DATA,   1'b0, slfr_pkg::STATUS_BUSY},
        '{OP_BYTE, 8'h00, SRC_DATA,   1'b0, slfr_pkg::STATUS_BUSY},
        '{OP_BYTE, 8'hFF, SRC_DATA,   1'b0, slfr_pkg::STATUS_BUSY},
        '{OP_BYTE, 8'h01, SRC_DATA,   1'b0, slfr_pkg::STATUS_BUSY},      // payload length
        '{OP_BYTE, 8'h00, SRC_DATA,   1'b0, slfr_pkg::STATUS_BUSY},
        '{OP_BYTE, 8'hFF, SRC_DATA,   1'b0, slfr_pkg::STATUS_BUSY},
        '{OP_BYTE, 8'hA5, SRC_DATA,   1'b0, slfr_pkg::STATUS_BUSY},      // command
        '{OP_BYTE, 8'h5A, SRC_DATA,   1'b0, slfr_pkg::STATUS_BUSY},      // payload
        '{OP_BYTE, 8'h00, SRC_CRC_LO, 1'b0, slfr_pkg::STATUS_BUSY},
        '{OP_BYTE, 8'h00, SRC_CRC_HI, 1'b0, slfr_pkg::STATUS_BUSY}
    };

    // ---------------------------------------------------------------- DUT
    logic                          aclk        = 1'b0;
    logic                          aresetn     = 1'b0;
    logic                          s_valid     = 1'b0;
    logic                          s_ready;
    logic                          s_operation = 1'b0;
    logic [7:0]                    s_rx_byte   = 8'h00;
    logic                          m_valid;
    logic                          m_ready     = 1'b0;
    logic [2:0]                    m_status;
    logic [7:0]                    m_payload_byte;
    logic [7:0]                    m_payload_index;
    logic [23:0]                   m_dest_address;
    logic [23:0]                   m_src_address;
    logic [7:0]                    m_payload_length;
    logic [7:0]                    m_command_code;
    logic                          psel        = 1'b0;
    logic                          penable     = 1'b0;
    logic                          pwrite      = 1'b0;
    logic [slfr_pkg::PADDR_W-1:0]  paddr       = '0;
    logic [31:0]                   pwdata      = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    sync_length_frame_receiver_crc_top u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_payload_byte   (m_payload_byte),
        .m_payload_index  (m_payload_index),
        .m_dest_address   (m_dest_address),
        .m_src_address    (m_src_address),
        .m_payload_length (m_payload_length),
        .m_command_code   (m_command_code),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // ---------------------------------------------------------------- predictor state
    // register copies, tracked as the bench writes them
    logic [15:0] poly_cfg    = slfr_pkg::CRC_POLY_RESET;
    logic [15:0] init_cfg    = slfr_pkg::CRC_INIT_RESET;
    logic [15:0] timeout_cfg = slfr_pkg::TIMEOUT_RESET;

    // frame being assembled
    logic [8:0]  rx_pos     = '0;
    logic [7:0]  rx_len     = '0;
    logic [15:0] rx_crc     = '0;
    logic [7:0]  rx_crc_lo  = '0;
    logic [23:0] rx_dst     = '0;
    logic [23:0] rx_src     = '0;
    logic [7:0]  rx_cmd     = '0;
    logic [15:0] idle_ticks = '0;

    slfr_pkg::result_t frame_results_due [$];   // results still to come, oldest first
    stim_t             plan_q [$];              // random sequence waiting to be sent
    int                mismatch_count = 0;
    int                stall_cycles   = 0;
    bit                tx_calm        = 1'b0;   // sender never idles while set
    logic              hold_armed     = 1'b0;   // asks the receiver for its long hold-off

    // Works out the result of one accepted item and advances the frame state.
    function automatic slfr_pkg::result_t frame_receive(input logic op, input logic [7:0] b);
        slfr_pkg::result_t r;
        logic [8:0]        p;
        logic [8:0]        crc_end;
        r = '0;
        if (op == OP_TICK) begin
            if (idle_ticks != slfr_pkg::IDLE_MAX)
                idle_ticks++;
            if (rx_pos != '0 && idle_ticks > timeout_cfg) begin
                rx_pos   = '0;
                r.status = slfr_pkg::STATUS_TIMEOUT;
            end
        end else begin
            p          = rx_pos;
            idle_ticks = '0;
            if ((p == '0 || p == slfr_pkg::POS_SYNC2) && b != slfr_pkg::SYNC_BYTE) begin
                rx_pos   = '0;
                r.status = slfr_pkg::STATUS_SYNC_DROP;
            end else begin
                // length as held before this byte; only matters past the header
                crc_end = slfr_pkg::HDR_SIZE + {1'b0, rx_len};
                if (p == '0)
                    rx_crc = init_cfg;
                if (p >= slfr_pkg::POS_DST_FIRST && p <= slfr_pkg::POS_DST_LAST)
                    rx_dst = {rx_dst[15:0], b};
                else if (p >= slfr_pkg::POS_SRC_FIRST && p <= slfr_pkg::POS_SRC_LAST)
                    rx_src = {rx_src[15:0], b};
                else if (p == slfr_pkg::POS_LEN)
                    rx_len = b;
                else if (p == slfr_pkg::POS_CMD)
                    rx_cmd = b;

                if (p < slfr_pkg::HDR_SIZE || p < crc_end) begin
                    rx_crc = rx_crc ^ {8'h00, b};
                    repeat (8)
                        rx_crc = rx_crc[0] ? ((rx_crc >> 1) ^ poly_cfg) : (rx_crc >> 1);
                end

                if (p >= slfr_pkg::HDR_SIZE && p < crc_end) begin
                    r.status        = slfr_pkg::STATUS_PAYLOAD;
                    r.payload_byte  = b;
                    r.payload_index = 8'(p - slfr_pkg::HDR_SIZE);
                    rx_pos          = p + 9'd1;
                end else if (p >= slfr_pkg::HDR_SIZE && p == crc_end) begin
                    rx_crc_lo = b;
                    rx_pos    = p + 9'd1;
                end else if (p >= slfr_pkg::HDR_SIZE && p == crc_end + 9'd1) begin
                    r.status         = ({b, rx_crc_lo} == rx_crc) ? slfr_pkg::STATUS_GOOD
                                                                  : slfr_pkg::STATUS_CRC_BAD;
                    r.dest_address   = rx_dst;
                    r.src_address    = rx_src;
                    r.payload_length = rx_len;
                    r.command_code   = rx_cmd;
                    rx_pos           = '0;
                end else begin
                    rx_pos = p + 9'd1;
                end
            end
        end
        return r;
    endfunction

    function automatic stim_t item_of(input logic op, input logic [7:0] data,
                                      input byte_src_t src);
        stim_t s;
        s            = '0;
        s.op         = op;
        s.data       = data;
        s.src        = src;
        s.lit_status = slfr_pkg::STATUS_BUSY;
        return s;
    endfunction

    // queue a frame byte, now and then with a stray tick ahead of it
    function automatic void plan_byte(input logic [7:0] data, input byte_src_t src);
        if ($urandom_range(99) < 3)
            plan_q = {plan_q, item_of(OP_TICK, 8'($urandom_range(255)), SRC_DATA)};
        plan_q = {plan_q, item_of(OP_BYTE, data, src)};
    endfunction

    // Offers one item and waits for it to be taken. ready is sampled on the
    // falling edge, so the decision never races the rising edge it refers to.
    task automatic send_item(input stim_t item);
        logic [7:0]        data;
        bit                taken;
        slfr_pkg::result_t due;
        while (!tx_calm && $urandom_range(99) < 38) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        // CRC bytes are resolved now, so they track any register change
        case (item.src)
            SRC_CRC_LO: data = rx_crc[7:0] ^ item.data;
            SRC_CRC_HI: data = rx_crc[15:8] ^ item.data;
            default:    data = item.data;
        endcase
        s_valid     <= 1'b1;
        s_operation <= item.op;
        s_rx_byte   <= data;
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end
        due = frame_receive(item.op, data);
        if (item.literal) begin
            due        = '0;
            due.status = item.lit_status;
        end
        frame_results_due = {frame_results_due, due};
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        s_valid <= 1'b0;
        while (frame_results_due.size() != 0)
            @(posedge aclk);
    endtask

    // APB write: setup, then access until pready; the copy follows the write
    task automatic write_reg(input slfr_pkg::reg_idx_t idx, input logic [15:0] value);
        bit done;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, value};
        @(posedge aclk);
        penable <= 1'b1;
        done = 1'b0;
        while (!done) begin
            @(negedge aclk);
            done = pready;
            @(posedge aclk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        case (idx)
            slfr_pkg::REG_CRC_POLY: poly_cfg    = value;
            slfr_pkg::REG_CRC_INIT: init_cfg    = value;
            default:                timeout_cfg = value;
        endcase
    endtask

    function automatic void check_field(input string name, input logic [23:0] want,
                                        input logic [23:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // ---------------------------------------------------------------- receiver side
    // Random back-pressure, a calm window with ready held high, and one long
    // hold-off once the stimulus asks for it, so the block fills and stalls.
    int unsigned rx_cycle  = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_armed && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_ready   <= 1'b0;
        end else if (rx_cycle >= RX_CALM_FIRST && rx_cycle < RX_CALM_LAST) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= 38);
        end
    end

    // ---------------------------------------------------------------- result check
    // Runs on the falling edge: a result seen here with valid and ready high is
    // taken at the next rising edge. Also the watchdog on stalled traffic.
    always @(negedge aclk) begin
        slfr_pkg::result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (frame_results_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got status %0d",
                             $time, m_status);
                    mismatch_count++;
                end else begin
                    want = frame_results_due.pop_front();
                    check_field("status",         want.status,         m_status);
                    check_field("payload_byte",   want.payload_byte,   m_payload_byte);
                    check_field("payload_index",  want.payload_index,  m_payload_index);
                    check_field("dest_address",   want.dest_address,   m_dest_address);
                    check_field("src_address",    want.src_address,    m_src_address);
                    check_field("payload_length", want.payload_length, m_payload_length);
                    check_field("command_code",   want.command_code,   m_command_code);
                end
            end
            if ((m_valid && m_ready) || (s_valid && s_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
                $display("sync_length_frame_receiver_crc_top regression: fail");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus
    initial begin
        int         random_items;
        int         phase;
        int         kind;
        int         flen;
        int         tick_cap;
        int         cut;
        bit         long_done;
        logic [7:0] sync2;
        logic [7:0] lo_mask;
        logic [7:0] hi_mask;

        random_items = 0;
        phase        = 0;
        long_done    = 1'b0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, both sync drops and a good frame at reset values
        foreach (DIRECTED[i])
            send_item(DIRECTED[i]);

        // random traffic in phases; a phase may start mid-frame, so register
        // changes land inside frames as well as between them
        while (random_items < RAND_ITEMS) begin
            if (random_items % PHASE_ITEMS == 0) begin
                drain();
                case (phase)
                    0: begin
                        write_reg(slfr_pkg::REG_CRC_POLY, 16'hFFFF);
                        write_reg(slfr_pkg::REG_CRC_INIT, 16'hFFFF);
                        write_reg(slfr_pkg::REG_TIMEOUT,  16'd1);
                    end
                    1: begin
                        // top timeout: a held frame never drops
                        write_reg(slfr_pkg::REG_CRC_POLY, 16'h0000);
                        write_reg(slfr_pkg::REG_CRC_INIT, 16'h0000);
                        write_reg(slfr_pkg::REG_TIMEOUT,  16'hFFFF);
                    end
                    2: begin
                        // zero timeout: the first tick drops a held frame
                        write_reg(slfr_pkg::REG_CRC_POLY, 16'h8408);
                        write_reg(slfr_pkg::REG_CRC_INIT, 16'h1D0F);
                        write_reg(slfr_pkg::REG_TIMEOUT,  16'd0);
                    end
                    3: begin
                        write_reg(slfr_pkg::REG_CRC_POLY, slfr_pkg::CRC_POLY_RESET);
                        write_reg(slfr_pkg::REG_CRC_INIT, 16'hFFFF);
                        write_reg(slfr_pkg::REG_TIMEOUT,  16'd3);
                    end
                    default: begin
                        write_reg(slfr_pkg::REG_CRC_POLY, 16'($urandom_range(16'hFFFF)));
                        write_reg(slfr_pkg::REG_CRC_INIT, 16'($urandom_range(16'hFFFF)));
                        write_reg(slfr_pkg::REG_TIMEOUT,  16'($urandom_range(1, 40)));
                    end
                endcase
                phase++;
            end

            if (plan_q.size() == 0) begin
                kind = $urandom_range(99);
                if (kind < 86) begin
                    // frame; some with a bad second sync, some cut short
                    kind = $urandom_range(99);
                    if (kind < 55)
                        flen = $urandom_range(4);
                    else if (kind < 85)
                        flen = $urandom_range(5, 20);
                    else
                        flen = $urandom_range(21, 40);
                    if (!long_done && random_items >= LONG_AFTER) begin
                        flen      = 255;
                        long_done = 1'b1;
                    end
                    sync2 = slfr_pkg::SYNC_BYTE;
                    if ($urandom_range(99) < 10) begin
                        sync2 = 8'($urandom_range(255));
                        if (sync2 == slfr_pkg::SYNC_BYTE)
                            sync2 = 8'h7F;
                    end
                    lo_mask = 8'h00;
                    hi_mask = 8'h00;
                    if ($urandom_range(99) < 20) begin
                        lo_mask = 8'($urandom_range(255));
                        hi_mask = 8'($urandom_range(lo_mask == 8'h00 ? 1 : 0, 255));
                    end
                    plan_byte(slfr_pkg::SYNC_BYTE, SRC_DATA);
                    repeat (4) plan_byte(8'($urandom_range(255)), SRC_DATA);
                    plan_byte(sync2, SRC_DATA);
                    repeat (4) plan_byte(8'($urandom_range(255)), SRC_DATA);
                    plan_byte(8'(flen), SRC_DATA);
                    repeat (3 + flen) plan_byte(8'($urandom_range(255)), SRC_DATA);
                    plan_byte(lo_mask, SRC_CRC_LO);
                    plan_byte(hi_mask, SRC_CRC_HI);
                    if ($urandom_range(99) < 10) begin
                        cut = $urandom_range(1, plan_q.size() - 1);
                        repeat (cut) void'(plan_q.pop_back());
                    end
                end else if (kind < 94) begin
                    // run of ticks, long enough to reach small timeouts
                    tick_cap = (timeout_cfg < 40) ? int'(timeout_cfg) + 2 : 40;
                    repeat ($urandom_range(tick_cap))
                        plan_q = {plan_q, item_of(OP_TICK, 8'($urandom_range(255)),
                                                  SRC_DATA)};
                end else begin
                    // noise
                    repeat ($urandom_range(1, 4))
                        plan_q = {plan_q, item_of(1'($urandom_range(1)),
                                                  8'($urandom_range(255)), SRC_DATA)};
                end
            end

            // one stretch with the sender offering in every cycle, but for the drain at a phase change
            tx_calm = (random_items >= TX_CALM_FIRST && random_items < TX_CALM_LAST);
            send_item(plan_q.pop_front());
            random_items++;
            if (random_items == 400)
                hold_armed <= 1'b1;
        end

        tx_calm = 1'b0;
        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && frame_results_due.size() == 0)
            $display("sync_length_frame_receiver_crc_top regression: pass");
        else
            $display("sync_length_frame_receiver_crc_top regression: fail");
        $finish;
    end

endmodule
